// ===== rtl/ubxp_pkg.sv =====
// ---------------------------------------------------------------------------
// ubxp_pkg
// Shared constants and types of the binary GPS frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

package ubxp_pkg;

    // sync and message codes
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] NAV_CLASS   = 8'h01;
    localparam logic [7:0] SOL_ID      = 8'h06;
    localparam logic [7:0] FIX_3D_CODE = 8'h03;

    // result status codes
    localparam int unsigned STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OTHER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NAV   = 2'd2;

    // field widths
    localparam int unsigned LEN_W         = 16;
    localparam int unsigned PAYLOAD_LEN_W = 10;
    localparam int unsigned POS_W         = 32;
    localparam int unsigned OFFSET_W      = 5;

    // payload offsets of the navigation solution fields
    localparam logic [OFFSET_W-1:0] FIX_OFFSET = 5'd10;
    localparam logic [OFFSET_W-1:0] POS_FIRST  = 5'd12;
    localparam logic [OFFSET_W-1:0] POS_END    = 5'd24;

    // capture control from the parser to the field capture
    typedef struct packed {
        logic                en;
        logic                in_window;
        logic [OFFSET_W-1:0] offset;
    } t_cap_ctrl;

endpackage

`default_nettype wire

// ===== rtl/ubxp_nav_capture.sv =====
// ---------------------------------------------------------------------------
// ubxp_nav_capture
// Holds the fix type and ECEF position bytes seen in the latest payloads.
// ---------------------------------------------------------------------------
`default_nettype none

module ubxp_nav_capture (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ubxp_pkg::t_cap_ctrl             i_ctrl,
    input  wire logic [7:0]                      i_byte,
    output logic [7:0]                           o_fix,
    output logic signed [ubxp_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [ubxp_pkg::POS_W-1:0]    o_pos_y,
    output logic signed [ubxp_pkg::POS_W-1:0]    o_pos_z
);

    logic [7:0]                  r_fix;
    logic [7:0]                  n_fix;
    logic [ubxp_pkg::POS_W-1:0]  r_pos [0:2];
    logic [ubxp_pkg::POS_W-1:0]  n_pos [0:2];
    logic [ubxp_pkg::OFFSET_W-1:0] pos_off;
    logic                        fix_hit;
    logic                        pos_hit;

    // decode the payload offset
    assign pos_off = i_ctrl.offset - ubxp_pkg::POS_FIRST;
    assign fix_hit = i_ctrl.en && i_ctrl.in_window && (i_ctrl.offset == ubxp_pkg::FIX_OFFSET);
    assign pos_hit = i_ctrl.en && i_ctrl.in_window
                     && (i_ctrl.offset >= ubxp_pkg::POS_FIRST)
                     && (i_ctrl.offset < ubxp_pkg::POS_END);

    // replace one byte lane of one position word
    always_comb begin
        n_fix = fix_hit ? i_byte : r_fix;
        for (int w = 0; w < 3; w++) begin
            n_pos[w] = r_pos[w];
            for (int l = 0; l < 4; l++) begin
                if (pos_hit && (pos_off[3:2] == 2'(w)) && (pos_off[1:0] == 2'(l))) begin
                    n_pos[w][8*l +: 8] = i_byte;
                end
            end
        end
    end

    // hold captured fields; they start at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix <= '0;
            for (int w = 0; w < 3; w++) begin
                r_pos[w] <= '0;
            end
        end else begin
            r_fix <= n_fix;
            for (int w = 0; w < 3; w++) begin
                r_pos[w] <= n_pos[w];
            end
        end
    end

    assign o_fix   = r_fix;
    assign o_pos_x = r_pos[0];
    assign o_pos_y = r_pos[1];
    assign o_pos_z = r_pos[2];

endmodule

`default_nettype wire

// ===== rtl/ubxp_frame_parser_top.sv =====
// ---------------------------------------------------------------------------
// ubx_frame_parser_top
// Frames binary GPS messages byte by byte and checks their Fletcher sum.
// Throughput: one byte beat per cycle unless a held result meets a downstream stall.
// The result is registered from the second checksum beat and shows in the next cycle.
// A held result stalls input only while the downstream stall is high.
// Reset (synchronous): parser hunts for sync, result empty, captures zero.
// ---------------------------------------------------------------------------
`default_nettype none

module ubx_frame_parser_top #(
    parameter int unsigned MAX_PAYLOAD = 512
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [7:0]                            i_rx_byte,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [ubxp_pkg::STATUS_W-1:0]              o_frame_status,
    output logic [7:0]                                 o_msg_class,
    output logic [7:0]                                 o_msg_id,
    output logic [ubxp_pkg::PAYLOAD_LEN_W-1:0]         o_payload_length,
    output logic [7:0]                                 o_fix_type,
    output logic                                       o_fix_3d,
    output logic signed [ubxp_pkg::POS_W-1:0]          o_ecef_x,
    output logic signed [ubxp_pkg::POS_W-1:0]          o_ecef_y,
    output logic signed [ubxp_pkg::POS_W-1:0]          o_ecef_z
);

    localparam int unsigned IDX_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [ubxp_pkg::LEN_W:0] MAX_LEN = (ubxp_pkg::LEN_W + 1)'(MAX_PAYLOAD);
    localparam logic [IDX_W-1:0] WINDOW_END = IDX_W'(ubxp_pkg::POS_END);

    typedef enum logic [3:0] {
        PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI,
        PH_PAYLOAD, PH_CHECK_A, PH_CHECK_B
    } t_phase;

    t_phase                          r_phase;
    t_phase                          n_phase;
    logic [7:0]                      r_class;
    logic [7:0]                      r_id;
    logic [ubxp_pkg::LEN_W-1:0]      r_len;
    logic [ubxp_pkg::LEN_W-1:0]      n_len_full;
    logic [IDX_W-1:0]                r_idx;
    logic [IDX_W-1:0]                n_idx;
    logic [7:0]                      r_sum_a;
    logic [7:0]                      r_sum_b;
    logic [7:0]                      n_sum_a;
    logic [7:0]                      n_sum_b;
    logic [7:0]                      r_check_a;
    logic                            r_out_valid;
    logic [ubxp_pkg::STATUS_W-1:0]   r_status;
    logic [ubxp_pkg::STATUS_W-1:0]   n_status;
    logic [7:0]                      r_out_class;
    logic [7:0]                      r_out_id;
    logic [ubxp_pkg::PAYLOAD_LEN_W-1:0] r_out_len;
    logic [7:0]                      r_out_fix;
    logic                            r_out_fix_3d;
    logic [ubxp_pkg::POS_W-1:0]      r_out_x;
    logic [ubxp_pkg::POS_W-1:0]      r_out_y;
    logic [ubxp_pkg::POS_W-1:0]      r_out_z;
    logic                            in_accept;
    logic                            out_accept;
    logic                            result_beat;
    logic                            good_nav;
    ubxp_pkg::t_cap_ctrl             cap_ctrl;
    logic [7:0]                      cap_fix;
    logic signed [ubxp_pkg::POS_W-1:0] cap_x;
    logic signed [ubxp_pkg::POS_W-1:0] cap_y;
    logic signed [ubxp_pkg::POS_W-1:0] cap_z;

    // handshake: stall input only while a held result cannot leave
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = r_out_valid && !i_out_stall;
    assign result_beat = in_accept && (r_phase == PH_CHECK_B);

    // running Fletcher sums and payload counters
    assign n_sum_a    = r_sum_a + i_rx_byte;
    assign n_sum_b    = r_sum_b + n_sum_a;
    assign n_len_full = {i_rx_byte, r_len[7:0]};
    assign n_idx      = r_idx + 1'b1;

    // verdict of the finished frame
    always_comb begin
        good_nav = (r_class == ubxp_pkg::NAV_CLASS) && (r_id == ubxp_pkg::SOL_ID);
        if ((r_sum_a == r_check_a) && (r_sum_b == i_rx_byte)) begin
            n_status = good_nav ? ubxp_pkg::STATUS_NAV : ubxp_pkg::STATUS_OTHER;
        end else begin
            n_status = ubxp_pkg::STATUS_BAD;
        end
    end

    // next phase
    always_comb begin
        unique case (r_phase)
            PH_SYNC1:   n_phase = (i_rx_byte == ubxp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2:   n_phase = (i_rx_byte == ubxp_pkg::SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            PH_CLASS:   n_phase = PH_ID;
            PH_ID:      n_phase = PH_LEN_LO;
            PH_LEN_LO:  n_phase = PH_LEN_HI;
            PH_LEN_HI: begin
                priority if ({1'b0, n_len_full} > MAX_LEN) n_phase = PH_SYNC1;
                else if (n_len_full == '0)                 n_phase = PH_CHECK_A;
                else                                       n_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: n_phase = (ubxp_pkg::LEN_W'(n_idx) >= r_len) ? PH_CHECK_A : PH_PAYLOAD;
            PH_CHECK_A: n_phase = PH_CHECK_B;
            PH_CHECK_B: n_phase = PH_SYNC1;
            default:    n_phase = (i_rx_byte == ubxp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
        endcase
    end

    // payload capture control
    assign cap_ctrl.en        = in_accept && (r_phase == PH_PAYLOAD);
    assign cap_ctrl.in_window = r_idx < WINDOW_END;
    assign cap_ctrl.offset    = r_idx[ubxp_pkg::OFFSET_W-1:0];

    ubxp_nav_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cap_ctrl),
        .i_byte  (i_rx_byte),
        .o_fix   (cap_fix),
        .o_pos_x (cap_x),
        .o_pos_y (cap_y),
        .o_pos_z (cap_z)
    );

    // parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC1;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase <= n_phase;
                unique case (r_phase)
                    PH_CLASS: begin
                        r_class <= i_rx_byte;
                        r_sum_a <= n_sum_a;
                        r_sum_b <= n_sum_b;
                    end
                    PH_ID: begin
                        r_id    <= i_rx_byte;
                        r_sum_a <= n_sum_a;
                        r_sum_b <= n_sum_b;
                    end
                    PH_LEN_LO: begin
                        r_len   <= {8'h00, i_rx_byte};
                        r_sum_a <= n_sum_a;
                        r_sum_b <= n_sum_b;
                    end
                    PH_LEN_HI: begin
                        r_len   <= n_len_full;
                        r_idx   <= '0;
                        r_sum_a <= n_sum_a;
                        r_sum_b <= n_sum_b;
                    end
                    PH_PAYLOAD: begin
                        r_idx   <= n_idx;
                        r_sum_a <= n_sum_a;
                        r_sum_b <= n_sum_b;
                    end
                    PH_CHECK_A: r_check_a <= i_rx_byte;
                    PH_SYNC2, PH_CHECK_B: begin
                    end
                    default: begin
                        r_sum_a <= '0;
                        r_sum_b <= '0;
                    end
                endcase
            end

            // load a result, or drop one that was taken
            if (result_beat) begin
                r_out_valid  <= 1'b1;
                r_status     <= n_status;
                r_out_class  <= r_class;
                r_out_id     <= r_id;
                r_out_len    <= r_len[ubxp_pkg::PAYLOAD_LEN_W-1:0];
                if (n_status == ubxp_pkg::STATUS_NAV) begin
                    r_out_fix    <= cap_fix;
                    r_out_fix_3d <= (cap_fix == ubxp_pkg::FIX_3D_CODE);
                    r_out_x      <= cap_x;
                    r_out_y      <= cap_y;
                    r_out_z      <= cap_z;
                end else begin
                    r_out_fix    <= '0;
                    r_out_fix_3d <= 1'b0;
                    r_out_x      <= '0;
                    r_out_y      <= '0;
                    r_out_z      <= '0;
                end
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_status   = r_status;
    assign o_msg_class      = r_out_class;
    assign o_msg_id         = r_out_id;
    assign o_payload_length = r_out_len;
    assign o_fix_type       = r_out_fix;
    assign o_fix_3d         = r_out_fix_3d;
    assign o_ecef_x         = r_out_x;
    assign o_ecef_y         = r_out_y;
    assign o_ecef_z         = r_out_z;

    // reset leaves the parser hunting with no result pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_SYNC1) && !r_out_valid)
        else $error("parser not idle after reset");

    // payload counter stays below the frame length
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (ubxp_pkg::LEN_W'(r_idx) < r_len))
        else $error("payload index past frame length");

    // a result is loaded only from the second checksum beat
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || out_accept) && !result_beat |=> !r_out_valid)
        else $error("result appeared without a checksum beat");

    // 3D fix flag only on a good navigation solution
    a_fix_3d_nav: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_fix_3d |-> (r_status == ubxp_pkg::STATUS_NAV))
        else $error("3D fix flagged on a non-navigation result");

    // status code stays within its defined range
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status == ubxp_pkg::STATUS_BAD)
                        || (r_status == ubxp_pkg::STATUS_OTHER)
                        || (r_status == ubxp_pkg::STATUS_NAV))
        else $error("undefined frame status");

endmodule

`default_nettype wire

// ===== test/ubx_frame_parser_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ubx_frame_parser_top_tb
// Feeds serial byte beats into the binary GPS frame parser and checks every
// result beat against a byte-level parser model kept inside the bench.
// Covers broken sync, oversized and empty payloads, short navigation frames,
// bad checksums, cut frames, line noise and long downstream stalls.
// ---------------------------------------------------------------------------

module ubx_frame_parser_top_tb;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_PAYLOAD    = 512;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int IDLE_PCT       = 22;
    localparam int RANDOM_BYTES   = 530;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [3:0] {
        PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI,
        PH_BODY, PH_CK_A, PH_CK_B
    } t_rx_phase;

    typedef enum int {CK_GOOD, CK_BAD_A, CK_BAD_B} t_ck_fault;

    typedef struct {
        logic [ubxp_pkg::STATUS_W-1:0]      status;
        logic [7:0]                         msg_class;
        logic [7:0]                         msg_id;
        logic [ubxp_pkg::PAYLOAD_LEN_W-1:0] length;
        logic [7:0]                         fix_type;
        logic                               fix_3d;
        logic signed [ubxp_pkg::POS_W-1:0]  ecef_x;
        logic signed [ubxp_pkg::POS_W-1:0]  ecef_y;
        logic signed [ubxp_pkg::POS_W-1:0]  ecef_z;
    } t_frame_result;

    // DUT ports
    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [7:0]                          i_rx_byte = 8'h00;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [ubxp_pkg::STATUS_W-1:0]       o_frame_status;
    logic [7:0]                          o_msg_class;
    logic [7:0]                          o_msg_id;
    logic [ubxp_pkg::PAYLOAD_LEN_W-1:0]  o_payload_length;
    logic [7:0]                          o_fix_type;
    logic                                o_fix_3d;
    logic signed [ubxp_pkg::POS_W-1:0]   o_ecef_x;
    logic signed [ubxp_pkg::POS_W-1:0]   o_ecef_y;
    logic signed [ubxp_pkg::POS_W-1:0]   o_ecef_z;

    // parser model state
    t_rx_phase       rx_phase = PH_SYNC1;
    logic [7:0]      hdr_class = 8'h00;
    logic [7:0]      hdr_id = 8'h00;
    logic [ubxp_pkg::LEN_W-1:0] hdr_length = '0;
    int              body_count = 0;
    logic [7:0]      fl_sum_a = 8'h00;
    logic [7:0]      fl_sum_b = 8'h00;
    logic [7:0]      got_check_a = 8'h00;
    logic [7:0]      held_fix = 8'h00;
    logic [ubxp_pkg::POS_W-1:0] held_pos [3] = '{default: '0};

    t_frame_result   expected_frames[$];
    logic [7:0]      frame_body[$];
    logic [7:0]      frame_bytes[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  hold_request = 0;
    int  hold_left = 0;
    bit  steady_flow = 1'b0;

    ubx_frame_parser_top #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_status   (o_frame_status),
        .o_msg_class      (o_msg_class),
        .o_msg_id         (o_msg_id),
        .o_payload_length (o_payload_length),
        .o_fix_type       (o_fix_type),
        .o_fix_3d         (o_fix_3d),
        .o_ecef_x         (o_ecef_x),
        .o_ecef_y         (o_ecef_y),
        .o_ecef_z         (o_ecef_z)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // downstream stall: random, quiet in steady stretches, solid on hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (steady_flow) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // compare each result beat with the oldest expected frame
    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_frames.size() == 0) begin
                report_mismatch($sformatf("result beat with no frame pending, status %h",
                                          o_frame_status));
            end else begin
                want = expected_frames.pop_front();
                check_field("frame_status", o_frame_status, want.status);
                check_field("msg_class", o_msg_class, want.msg_class);
                check_field("msg_id", o_msg_id, want.msg_id);
                check_field("payload_length", o_payload_length, want.length);
                check_field("fix_type", o_fix_type, want.fix_type);
                check_field("fix_3d", o_fix_3d, want.fix_3d);
                check_field("ecef_x", o_ecef_x, want.ecef_x);
                check_field("ecef_y", o_ecef_y, want.ecef_y);
                check_field("ecef_z", o_ecef_z, want.ecef_z);
            end
        end
    end

    task automatic fold_sum(input logic [7:0] b);
        fl_sum_a = fl_sum_a + b;
        fl_sum_b = fl_sum_b + fl_sum_a;
    endtask

    // advance the parser model by one accepted byte
    task automatic track_rx_byte(input logic [7:0] b);
        t_frame_result r;
        int            off;
        case (rx_phase)
            PH_SYNC2: rx_phase = (b == ubxp_pkg::SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            PH_CLASS: begin
                hdr_class = b;
                fold_sum(b);
                rx_phase = PH_ID;
            end
            PH_ID: begin
                hdr_id = b;
                fold_sum(b);
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                hdr_length = {8'h00, b};
                fold_sum(b);
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                hdr_length[15:8] = b;
                fold_sum(b);
                body_count = 0;
                if (hdr_length > MAX_PAYLOAD)
                    rx_phase = PH_SYNC1;
                else if (hdr_length == 0)
                    rx_phase = PH_CK_A;
                else
                    rx_phase = PH_BODY;
            end
            PH_BODY: begin
                // capture fix and position bytes of any frame
                if (body_count == ubxp_pkg::FIX_OFFSET) begin
                    held_fix = b;
                end else if (body_count >= ubxp_pkg::POS_FIRST &&
                             body_count < ubxp_pkg::POS_END) begin
                    off = body_count - ubxp_pkg::POS_FIRST;
                    held_pos[off / 4][(off % 4) * 8 +: 8] = b;
                end
                fold_sum(b);
                body_count++;
                if (body_count >= hdr_length)
                    rx_phase = PH_CK_A;
            end
            PH_CK_A: begin
                got_check_a = b;
                rx_phase = PH_CK_B;
            end
            PH_CK_B: begin
                r = '{default: '0};
                if (fl_sum_a == got_check_a && fl_sum_b == b)
                    r.status = (hdr_class == ubxp_pkg::NAV_CLASS &&
                                hdr_id == ubxp_pkg::SOL_ID) ?
                               ubxp_pkg::STATUS_NAV : ubxp_pkg::STATUS_OTHER;
                else
                    r.status = ubxp_pkg::STATUS_BAD;
                r.msg_class = hdr_class;
                r.msg_id    = hdr_id;
                r.length    = hdr_length[ubxp_pkg::PAYLOAD_LEN_W-1:0];
                if (r.status == ubxp_pkg::STATUS_NAV) begin
                    r.fix_type = held_fix;
                    r.fix_3d   = (held_fix == ubxp_pkg::FIX_3D_CODE);
                    r.ecef_x   = held_pos[0];
                    r.ecef_y   = held_pos[1];
                    r.ecef_z   = held_pos[2];
                end
                expected_frames.push_back(r);
                rx_phase = PH_SYNC1;
            end
            default: begin
                fl_sum_a = 8'h00;
                fl_sum_b = 8'h00;
                rx_phase = (b == ubxp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    endtask

    // offer one byte beat, idling at random first, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // bytes dropped while hunting for sync do not count
        if (rx_phase != PH_SYNC1 || b == ubxp_pkg::SYNC_FIRST)
            items_sent++;
        track_rx_byte(b);
    endtask

    // drop valid and wait until every pending frame result has come out
    task automatic wait_results_drained;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_frames.size() != 0);
    endtask

    task automatic fill_body(input int n);
        frame_body.delete();
        repeat (n) frame_body.push_back(8'($urandom));
    endtask

    task automatic set_pos_word(input int at, input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            frame_body[at + k] = w[k * 8 +: 8];
    endtask

    // send sync, header, frame_body and checksum; keep < 0 sends it all
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input t_ck_fault fault,
                              input int keep);
        logic [7:0] ca;
        logic [7:0] cb;
        int         n;
        ca = 8'h00;
        cb = 8'h00;
        frame_bytes = {ubxp_pkg::SYNC_FIRST, ubxp_pkg::SYNC_SECOND, cls, id,
                       len[7:0], len[15:8]};
        foreach (frame_body[i]) frame_bytes.push_back(frame_body[i]);
        for (int i = 2; i < frame_bytes.size(); i++) begin
            ca = ca + frame_bytes[i];
            cb = cb + ca;
        end
        if (fault == CK_BAD_A)
            ca = ca ^ 8'($urandom_range(1, 255));
        else if (fault == CK_BAD_B)
            cb = cb ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(ca);
        frame_bytes.push_back(cb);
        n = (keep < 0 || keep > frame_bytes.size()) ? frame_bytes.size() : keep;
        for (int i = 0; i < n; i++)
            send_byte(frame_bytes[i]);
    endtask

    // a sync byte not followed by the second sync must not open a frame
    task automatic test_broken_sync;
        send_byte(ubxp_pkg::SYNC_FIRST);
        send_byte(ubxp_pkg::SYNC_FIRST);
        send_byte(ubxp_pkg::SYNC_SECOND);
        // empty payload jumps straight to the checksum
        frame_body.delete();
        send_frame(8'hFF, 8'h00, 16'd0, CK_GOOD, -1);
        wait_results_drained();
    endtask

    // oversized lengths drop the frame with no result
    task automatic test_oversized_length;
        frame_body.delete();
        send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::SOL_ID, 16'(MAX_PAYLOAD + 1),
                   CK_GOOD, 6);
        send_frame(8'h00, 8'hFF, 16'hFFFF, CK_GOOD, 6);
        send_frame(8'h0A, 8'h04, 16'd0, CK_GOOD, -1);
        wait_results_drained();
    endtask

    // full navigation solution, then a short one that reports held values
    task automatic test_nav_solution;
        fill_body(24);
        frame_body[10] = ubxp_pkg::FIX_3D_CODE;
        set_pos_word(12, 32'h8000_0000);
        set_pos_word(16, 32'h7FFF_FFFF);
        set_pos_word(20, 32'hFFFF_FFFF);
        send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::SOL_ID, 16'd24, CK_GOOD, -1);
        fill_body(11);
        frame_body[10] = 8'h02;
        send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::SOL_ID, 16'd11, CK_GOOD, -1);
        wait_results_drained();
    endtask

    task automatic test_bad_checksum;
        fill_body(3);
        send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::SOL_ID, 16'd3, CK_BAD_A, -1);
        fill_body(1);
        send_frame(8'h05, 8'h01, 16'd1, CK_BAD_B, -1);
        wait_results_drained();
    endtask

    // hold off downstream while frames keep coming, so the input backs up
    task automatic test_receiver_holdoff;
        hold_request = HOLDOFF_CYCLES;
        repeat (12) begin
            fill_body($urandom_range(0, 4));
            send_frame(8'($urandom), 8'($urandom), 16'(frame_body.size()), CK_GOOD, -1);
        end
        wait_results_drained();
    endtask

    // mostly well-formed frames with random content, plus noise and cut frames
    task automatic test_random_traffic;
        int         start_items;
        int         frame_no;
        int         pick;
        int         len;
        int         keep;
        int         big_frames;
        bit         nav;
        logic [7:0] cls;
        logic [7:0] id;
        t_ck_fault  fault;
        start_items   = items_sent;
        frame_no      = 0;
        big_frames    = 0;
        while (items_sent - start_items < RANDOM_BYTES) begin
            steady_flow = (frame_no >= 5 && frame_no < 15);
            pick = $urandom_range(99);
            if (pick < 8) begin
                // line noise
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else if (pick < 14) begin
                len = ($urandom_range(3) == 0) ? 16'hFFFF :
                      $urandom_range(MAX_PAYLOAD + 1, 65535);
                frame_body.delete();
                send_frame(8'($urandom), 8'($urandom), 16'(len), CK_GOOD, 6);
            end else begin
                nav = (pick < 50);
                cls = (nav || $urandom_range(3) == 0) ? ubxp_pkg::NAV_CLASS :
                      8'($urandom);
                id  = (nav || $urandom_range(3) == 0) ? ubxp_pkg::SOL_ID :
                      8'($urandom);
                if (big_frames < 2 && $urandom_range(99) < 2) begin
                    len = MAX_PAYLOAD;
                    big_frames++;
                end else if (nav) begin
                    len = ($urandom_range(99) < 70) ? $urandom_range(24, 40) :
                          $urandom_range(0, 23);
                end else begin
                    len = ($urandom_range(99) < 10) ? $urandom_range(41, 200) :
                          $urandom_range(0, 40);
                end
                fill_body(len);
                if (len > 10 && $urandom_range(1))
                    frame_body[10] = ubxp_pkg::FIX_3D_CODE;
                fault = ($urandom_range(99) >= 15) ? CK_GOOD :
                        ($urandom_range(1) ? CK_BAD_A : CK_BAD_B);
                // a cut frame leaves the parser mid-frame for what follows
                keep = (pick < 22) ? $urandom_range(1, len + 7) : -1;
                send_frame(cls, id, 16'(len), fault, keep);
            end
            frame_no++;
        end
        steady_flow = 1'b0;
        wait_results_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_broken_sync();
        test_oversized_length();
        test_nav_solution();
        test_bad_checksum();
        test_receiver_holdoff();
        test_random_traffic();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
